[rtl/md5_pkg.sv]
// ----------------------------------------------------------------------------
// MD5 package
// Shared constants, types and round tables for the MD5 engine.
// ----------------------------------------------------------------------------
package md5_pkg;

  localparam int unsigned BlockBytes = 64;
  localparam int unsigned FillW      = 6;
  localparam int unsigned Rounds     = 64;
  localparam int unsigned RoundW     = 6;

  localparam logic [31:0] InitA = 32'h67452301;
  localparam logic [31:0] InitB = 32'hefcdab89;
  localparam logic [31:0] InitC = 32'h98badcfe;
  localparam logic [31:0] InitD = 32'h10325476;

  localparam logic [7:0] PadByte    = 8'h80;
  localparam logic [5:0] LenStart   = 6'd56;

  // Byte source select for the block buffer write.
  localparam logic [1:0] SRC_DATA = 2'd0;
  localparam logic [1:0] SRC_PAD  = 2'd1;
  localparam logic [1:0] SRC_ZERO = 2'd2;
  localparam logic [1:0] SRC_LEN  = 2'd3;

  typedef struct packed {
    logic       init;       // reload initial chain, clear counts
    logic       wr;         // write one byte into the block buffer
    logic [1:0] src;        // byte source
    logic       add_bits;   // advance the bit count by 8
    logic       latch_len;  // capture bit count for the length field
    logic       rd;         // read one buffer word (round word fetch)
    logic       rnd_start;  // load working registers from chain
    logic       rnd;        // run one round
    logic       rnd_fin;    // fold working registers into chain
    logic       out_load;   // capture digest into output register
  } md5_cmd_t;

  typedef struct packed {
    logic [FillW-1:0] fill;
    logic             fill_full;  // buffer just wrapped to zero after 64 bytes
  } md5_sts_t;

  function automatic logic [31:0] round_const(input logic [5:0] i);
    logic [31:0] k [64];
    k = '{
      32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
      32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
      32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
      32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
      32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
      32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
      32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
      32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
      32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
      32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
      32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
      32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
      32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
      32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
      32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
      32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391};
    return k[i];
  endfunction

  function automatic logic [4:0] rot_amount(input logic [5:0] i);
    logic [4:0] r;
    case ({i[5:4], i[1:0]})
      4'h0: r = 5'd7;  4'h1: r = 5'd12; 4'h2: r = 5'd17; 4'h3: r = 5'd22;
      4'h4: r = 5'd5;  4'h5: r = 5'd9;  4'h6: r = 5'd14; 4'h7: r = 5'd20;
      4'h8: r = 5'd4;  4'h9: r = 5'd11; 4'ha: r = 5'd16; 4'hb: r = 5'd23;
      4'hc: r = 5'd6;  4'hd: r = 5'd10; 4'he: r = 5'd15; default: r = 5'd21;
    endcase
    return r;
  endfunction

  // Message word index used by round i.
  function automatic logic [3:0] word_index(input logic [5:0] i);
    logic [3:0] g;
    case (i[5:4])
      2'd0:    g = i[3:0];
      2'd1:    g = 4'(5 * i[3:0] + 1);
      2'd2:    g = 4'(3 * i[3:0] + 5);
      default: g = 4'(7 * i[3:0]);
    endcase
    return g;
  endfunction

endpackage

[rtl/md5_datapath.sv]
// ----------------------------------------------------------------------------
// MD5 datapath
// Block buffer, counters, round registers and digest output register.
// ----------------------------------------------------------------------------
module md5_datapath (
  input  logic                clk,
  input  logic                rst,
  input  md5_pkg::md5_cmd_t   cmd,
  input  logic [7:0]          data_byte,
  input  logic [5:0]          rd_round,
  output md5_pkg::md5_sts_t   sts,
  output logic [63:0]         digest_low,
  output logic [63:0]         digest_high
);
  import md5_pkg::*;

  logic [31:0] buffer [16];
  logic [31:0] word_rd;
  logic [31:0] chain [4];
  logic [31:0] a, b, c, d;
  logic [5:0]  round;
  logic [FillW-1:0] fill;
  logic        fill_full;
  logic [63:0] bits;
  logic [63:0] len;
  logic [7:0]  wbyte;
  logic [31:0] f, tmp, rot, sum;
  logic [4:0]  s;

  always_comb begin
    case (cmd.src)
      SRC_DATA: wbyte = data_byte;
      SRC_PAD:  wbyte = PadByte;
      SRC_ZERO: wbyte = 8'h00;
      default:  wbyte = len[8*(fill[2:0])+:8];
    endcase
  end

  // Buffer is 16 words; bytes written into lanes little-endian.
  always_ff @(posedge clk) begin
    if (cmd.wr) begin
      buffer[fill[5:2]][8*fill[1:0]+:8] <= wbyte;
    end
    if (cmd.rd) begin
      word_rd <= buffer[word_index(rd_round)];
    end
    if (cmd.latch_len) begin
      len <= bits;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.init) begin
      fill      <= '0;
      fill_full <= 1'b0;
      bits      <= '0;
    end else begin
      if (cmd.add_bits) begin
        bits <= bits + 64'd8;
      end
      if (cmd.wr) begin
        fill      <= fill + 1'b1;
        fill_full <= (fill == FillW'(BlockBytes - 1));
      end else begin
        fill_full <= 1'b0;
      end
    end
  end

  always_comb begin
    case (round[5:4])
      2'd0:    f = (b & c) | (~b & d);
      2'd1:    f = (b & d) | (c & ~d);
      2'd2:    f = b ^ c ^ d;
      default: f = c ^ (b | ~d);
    endcase
    s   = rot_amount(round);
    sum = a + f + word_rd + round_const(round);
    rot = (sum << s) | (sum >> (6'd32 - {1'b0, s}));
    tmp = b + rot;
  end

  always_ff @(posedge clk) begin
    if (rst || cmd.init) begin
      chain[0] <= InitA;
      chain[1] <= InitB;
      chain[2] <= InitC;
      chain[3] <= InitD;
      round    <= '0;
    end else if (cmd.rnd_start) begin
      a     <= chain[0];
      b     <= chain[1];
      c     <= chain[2];
      d     <= chain[3];
      round <= '0;
    end else if (cmd.rnd) begin
      a     <= d;
      d     <= c;
      c     <= b;
      b     <= tmp;
      round <= round + 1'b1;
    end else if (cmd.rnd_fin) begin
      chain[0] <= chain[0] + a;
      chain[1] <= chain[1] + b;
      chain[2] <= chain[2] + c;
      chain[3] <= chain[3] + d;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      digest_low  <= {chain[1], chain[0]};
      digest_high <= {chain[3], chain[2]};
    end
  end

  assign sts.fill      = fill;
  assign sts.fill_full = fill_full;

endmodule

[rtl/md5_ctrl.sv]
// ----------------------------------------------------------------------------
// MD5 controller
// Sequences byte intake, padding, compression and digest hand-off.
// ----------------------------------------------------------------------------
module md5_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_tvalid,
  output logic               in_tready,
  input  logic               byte_present,
  input  logic               last,
  output logic               out_tvalid,
  input  logic               out_tready,
  input  md5_pkg::md5_sts_t  sts,
  output md5_pkg::md5_cmd_t  cmd,
  output logic [5:0]         rd_round
);
  import md5_pkg::*;

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_FETCH = 3'd1;
  localparam logic [2:0] ST_ROUND = 3'd2;
  localparam logic [2:0] ST_FOLD  = 3'd3;
  localparam logic [2:0] ST_PAD   = 3'd4;
  localparam logic [2:0] ST_OUT   = 3'd5;
  localparam logic [2:0] ST_LOAD  = 3'd6;

  logic [2:0] state, state_next;
  logic [5:0] cnt, cnt_next;
  logic       ending, ending_next;   // message end pending
  logic       padded, padded_next;   // 0x80 byte already written
  logic       in_len, in_len_next;   // length field being written
  logic       lenblk, lenblk_next;   // length written, final block in flight
  logic       acc;
  logic       blk_end;

  assign in_tready  = (state == ST_IDLE);
  assign out_tvalid = (state == ST_OUT);
  assign acc        = in_tvalid && in_tready;
  assign blk_end    = (sts.fill == FillW'(BlockBytes - 1));
  // fetch the word for the round after the one running now
  assign rd_round   = (state == ST_ROUND) ? cnt + 6'd1 : 6'd0;

  always_comb begin
    state_next  = state;
    cnt_next    = cnt;
    ending_next = ending;
    padded_next = padded;
    in_len_next = in_len;
    lenblk_next = lenblk;
    cmd         = '0;
    case (state)
      ST_IDLE: begin
        if (acc) begin
          cmd.wr       = byte_present;
          cmd.src      = SRC_DATA;
          cmd.add_bits = byte_present;
          ending_next  = last;
          if (byte_present && blk_end) begin
            state_next = ST_FETCH;
          end else if (last) begin
            state_next = ST_PAD;
          end
        end
      end
      ST_FETCH: begin
        cmd.rnd_start = 1'b1;
        cmd.rd        = 1'b1;
        cnt_next      = 6'd0;
        state_next    = ST_ROUND;
      end
      ST_ROUND: begin
        cmd.rnd  = 1'b1;
        cmd.rd   = 1'b1;
        cnt_next = cnt + 6'd1;
        if (cnt == RoundW'(Rounds - 1)) begin
          state_next = ST_FOLD;
        end
      end
      ST_FOLD: begin
        cmd.rnd_fin = 1'b1;
        if (lenblk) begin
          state_next = ST_LOAD;
        end else if (ending) begin
          state_next = ST_PAD;
        end else begin
          state_next = ST_IDLE;
        end
      end
      ST_PAD: begin
        cmd.wr = 1'b1;
        if (!padded) begin
          cmd.latch_len = 1'b1;
          cmd.src       = SRC_PAD;
          padded_next   = 1'b1;
        end else if (in_len || sts.fill == LenStart) begin
          cmd.src     = SRC_LEN;
          in_len_next = 1'b1;
          if (blk_end) begin
            lenblk_next = 1'b1;
          end
        end else begin
          cmd.src = SRC_ZERO;
        end
        // a write that fills the block goes straight to compression
        if (blk_end) begin
          state_next = ST_FETCH;
        end
      end
      ST_LOAD: begin
        // capture the folded chain, then reload it for the next message
        cmd.out_load = 1'b1;
        cmd.init     = 1'b1;
        ending_next  = 1'b0;
        padded_next  = 1'b0;
        in_len_next  = 1'b0;
        lenblk_next  = 1'b0;
        state_next   = ST_OUT;
      end
      ST_OUT: begin
        if (out_tready) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ST_IDLE;
      cnt    <= '0;
      ending <= 1'b0;
      padded <= 1'b0;
      in_len <= 1'b0;
      lenblk <= 1'b0;
    end else begin
      state  <= state_next;
      cnt    <= cnt_next;
      ending <= ending_next;
      padded <= padded_next;
      in_len <= in_len_next;
      lenblk <= lenblk_next;
    end
  end

  assert property (@(posedge clk) disable iff (rst) in_tready |-> !out_tvalid)
    else $error("input accepted while digest pending");
  assert property (@(posedge clk) disable iff (rst)
    (state == ST_ROUND) |=> (state == ST_ROUND || state == ST_FOLD))
    else $error("round sequence broken");
  assert property (@(posedge clk) disable iff (rst)
    (out_tvalid && !out_tready) |=> out_tvalid)
    else $error("digest dropped before transfer");
  assert property (@(posedge clk) disable iff (rst)
    sts.fill_full |-> (state == ST_FETCH))
    else $error("full block not sent to compression");

endmodule

[rtl/md5_message_digest.sv]
// ----------------------------------------------------------------------------
// MD5 message digest
// Byte-serial MD5 engine with controller and datapath.
//
//  channel  dir  handshake              payload
//  s_axis   in   tvalid/tready          tdata[7:0]=data_byte, tuser=byte_present,
//                                       tlast=last
//  m_axis   out  tvalid/tready          tdata[63:0]=digest_low, [127:64]=digest_high
//
// One byte is taken per cycle; a full block then stalls the input for the
// fetch, the 64 rounds and the fold in the single round unit. A last item adds
// padding bytes one per cycle, one or two compressions and a load of the
// digest. Input stalls while a digest waits. rst is synchronous and
// restores the MD5 initial chain.
// ----------------------------------------------------------------------------
module md5_message_digest (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [7:0]   s_axis_tdata,   // data_byte
  input  logic         s_axis_tuser,   // byte_present
  input  logic         s_axis_tlast,   // last
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [127:0] m_axis_tdata    // digest_low, digest_high
);
  import md5_pkg::*;

  md5_cmd_t cmd;
  md5_sts_t sts;
  logic [5:0] rd_round;
  logic [63:0] dl, dh;

  md5_ctrl u_ctrl (
    .clk, .rst,
    .in_tvalid(s_axis_tvalid), .in_tready(s_axis_tready),
    .byte_present(s_axis_tuser), .last(s_axis_tlast),
    .out_tvalid(m_axis_tvalid), .out_tready(m_axis_tready),
    .sts, .cmd, .rd_round
  );

  md5_datapath u_dp (
    .clk, .rst, .cmd, .data_byte(s_axis_tdata), .rd_round,
    .sts, .digest_low(dl), .digest_high(dh)
  );

  assign m_axis_tdata = {dh, dl};

endmodule

[verif/testbench.sv]
// ----------------------------------------------------------------------------
// MD5 message digest testbench
// Streams random and directed messages into the byte-serial MD5 engine,
// predicts each digest with an independent MD5 model and compares every
// digest transfer against the oldest pending prediction.
// ----------------------------------------------------------------------------
class md5_scoreboard;
  logic [31:0] chain [4];
  logic [7:0]  buf_bytes [64];
  int unsigned fill;
  logic [63:0] bit_count;
  logic [127:0] pending [$];
  int unsigned errors;

  function new();
    restart();
    errors = 0;
  endfunction

  function void restart();
    chain[0] = 32'h67452301; chain[1] = 32'hefcdab89;
    chain[2] = 32'h98badcfe; chain[3] = 32'h10325476;
    fill = 0;
    bit_count = '0;
  endfunction

  function void compress();
    logic [31:0] w [16];
    logic [31:0] a, b, c, d, f, t;
    int unsigned g, ph;
    for (int i = 0; i < 16; i++)
      w[i] = {buf_bytes[4*i+3], buf_bytes[4*i+2], buf_bytes[4*i+1], buf_bytes[4*i]};
    a = chain[0]; b = chain[1]; c = chain[2]; d = chain[3];
    for (int i = 0; i < 64; i++) begin
      ph = i / 16;
      case (ph)
        0: begin f = (b & c) | (~b & d); g = i; end
        1: begin f = (b & d) | (c & ~d); g = (5*i + 1) % 16; end
        2: begin f = b ^ c ^ d; g = (3*i + 5) % 16; end
        default: begin f = c ^ (b | ~d); g = (7*i) % 16; end
      endcase
      t = a + f + w[g] + md5_const(i);
      t = (t << md5_shift(ph, i % 4)) | (t >> (32 - md5_shift(ph, i % 4)));
      a = d; d = c; c = b; b = b + t;
    end
    chain[0] += a; chain[1] += b; chain[2] += c; chain[3] += d;
  endfunction

  function int unsigned md5_shift(int unsigned ph, int unsigned k);
    int unsigned s [16] = '{7, 12, 17, 22, 5, 9, 14, 20, 4, 11, 16, 23, 6, 10, 15, 21};
    return s[ph*4 + k];
  endfunction

  // Sine-derived constants: floor(abs(sin(i+1)) * 2^32)
  function logic [31:0] md5_const(int i);
    logic [31:0] k [64] = '{
      32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
      32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
      32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
      32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
      32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
      32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
      32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
      32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
      32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
      32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
      32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
      32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
      32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
      32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
      32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
      32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391};
    return k[i];
  endfunction

  function void append(logic [7:0] v);
    buf_bytes[fill] = v;
    fill++;
    if (fill == 64) begin
      compress();
      fill = 0;
    end
  endfunction

  function void note_input(logic [7:0] data, logic present, logic last);
    logic [63:0] total;
    if (present) begin
      bit_count += 64'd8;
      append(data);
    end
    if (!last) return;
    total = bit_count;
    append(8'h80);
    while (fill != 56) append(8'h00);
    for (int i = 0; i < 8; i++) append(total[8*i +: 8]);
    pending.push_back({chain[3], chain[2], chain[1], chain[0]});
    restart();
  endfunction

  function void check_digest(logic [127:0] got);
    logic [127:0] exp;
    if (pending.size() == 0) begin
      $error("digest with no message pending: %h", got);
      errors++;
      return;
    end
    exp = pending.pop_front();
    if (got[63:0] !== exp[63:0]) begin
      $error("digest_low expected %h actual %h", exp[63:0], got[63:0]);
      errors++;
    end
    if (got[127:64] !== exp[127:64]) begin
      $error("digest_high expected %h actual %h", exp[127:64], got[127:64]);
      errors++;
    end
  endfunction
endclass

module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [7:0]   s_axis_tdata = '0;
  logic         s_axis_tuser = 1'b0;
  logic         s_axis_tlast = 1'b0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [127:0] m_axis_tdata;

  md5_scoreboard digests = new();
  bit      calm = 1'b0;      // no idling on either side
  int      hold_off = 0;     // receiver stall cycles left
  int      digest_count = 0;

  md5_message_digest u_top (.*);

  initial begin
    forever #5 clk = ~clk;
  end

  // Send one byte item; idle at random before it.
  task automatic send_item(logic [7:0] data, logic present, logic last);
    while (!calm && $urandom_range(99) < 31) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= data;
    s_axis_tuser  <= present;
    s_axis_tlast  <= last;
    do @(posedge clk); while (!s_axis_tready);
    digests.note_input(data, present, last);
  endtask

  task automatic send_message(int unsigned len, bit tail_byte, bit noise);
    for (int i = 0; i < len; i++) begin
      if (noise && $urandom_range(9) == 0) send_item(8'($urandom), 1'b0, 1'b0);
      send_item(8'($urandom), 1'b1, 1'b0);
    end
    send_item(8'($urandom), tail_byte, 1'b1);
  endtask

  always @(posedge clk) begin
    if (rst) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        digests.check_digest(m_axis_tdata);
        digest_count++;
      end
      if (hold_off > 0) begin
        hold_off--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= calm || ($urandom_range(99) >= 31);
      end
    end
  end

  initial begin
    int unsigned sent;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: empty messages, extreme bytes, block boundaries
    send_item(8'h00, 1'b0, 1'b1);
    send_item(8'h00, 1'b0, 1'b0);
    send_item(8'h00, 1'b1, 1'b1);
    send_item(8'hff, 1'b1, 1'b1);
    send_item(8'h61, 1'b1, 1'b0);
    send_item(8'h62, 1'b1, 1'b0);
    send_item(8'h63, 1'b0, 1'b1);
    send_item(8'haa, 1'b1, 1'b0);
    send_item(8'h55, 1'b1, 1'b1);
    send_message(54, 1'b1, 1'b0);
    send_message(55, 1'b1, 1'b0);
    send_message(63, 1'b1, 1'b0);
    send_message(64, 1'b0, 1'b0);

    // Long receiver stall while more messages are offered at the input
    hold_off = 600;
    for (int i = 0; i < 4; i++)
      send_message($urandom_range(0, 8), 1'($urandom_range(1)), 1'b0);

    sent = 0;
    while (sent < 1600) begin
      int unsigned len;
      calm = (sent > 700 && sent < 1000);
      len = ($urandom_range(9) == 0) ? $urandom_range(56, 130) : $urandom_range(0, 20);
      send_message(len, 1'($urandom_range(1)), 1'b1);
      sent += len + 1;
    end
    calm = 1'b0;
    s_axis_tvalid <= 1'b0;

    while (digests.pending.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);
    if (digests.errors == 0)
      $display("testbench: PASS");
    else
      $display("testbench: FAIL");
    $finish;
  end

  initial begin
    #5ms;
    $display("testbench: FAIL");
    $finish;
  end
endmodule
